// File: rtl/core/grid_max_path_sum_with_backtrack_defines.svh
// Assertion macros for the grid max path sum block.
// Used by the checker; depends on a clk and rst in scope.
`ifndef GRID_MAX_PATH_SUM_WITH_BACKTRACK_DEFINES_SVH
`define GRID_MAX_PATH_SUM_WITH_BACKTRACK_DEFINES_SVH

// same-cycle implication
`define GMPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gmps_pkg.sv
// Shared types and constants for the grid max path sum block.
// No dependencies.
package gmps_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIM_W    = 4;
  localparam int WGT_W    = 8;
  localparam int SUM_W    = 12;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(4);
  localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(5);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic cell_en;
    logic rd_en;
    logic step_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic map_end;
    logic at_start;
  } dp_status_t;

endpackage

// File: rtl/core/gmps_ctrl.sv
// Controller FSM: cell intake, then backtrack lookup/emit sequence.
// Depends on gmps_pkg.
module gmps_ctrl
  import gmps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       result_strobe
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && status.map_end) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = status.at_start ? ST_IDLE : ST_LOOKUP;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    busy          = 1'b1;
    result_strobe = 1'b0;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.cell_en = start;
      end
      ST_LOOKUP: begin
        cmd.rd_en = 1'b1;
      end
      ST_EMIT: begin
        cmd.step_en   = 1'b1;
        result_strobe = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/gmps_datapath.sv
// Datapath: size registers, row sums, predecessor bit memory, walk position.
// Depends on gmps_pkg.
module gmps_datapath
  import gmps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic signed [WGT_W-1:0] cell_weight,
  output dp_status_t              status,
  output logic [ROW_W-1:0]        path_row,
  output logic [COL_W-1:0]        path_col,
  output logic signed [SUM_W-1:0] best_total
);

  logic [DIM_W-1:0] rows_in_use;
  logic [DIM_W-1:0] cols_in_use;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] row_sums [MAX_COLS];
  logic from_left [MAX_ROWS*MAX_COLS];
  logic [ROW_W-1:0] pr;
  logic [COL_W-1:0] pc;
  logic signed [SUM_W-1:0] tot;
  logic rd_bit;

  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;
  logic col_end;
  logic row_end;
  logic signed [SUM_W-1:0] w_ext;
  logic signed [SUM_W-1:0] up_sum;
  logic signed [SUM_W-1:0] s;
  logic bit_left;

  // 0 acts as 1, values past the maximum act as the maximum
  function automatic logic [ROW_W-1:0] last_row_of(input logic [DIM_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > DIM_W'(MAX_ROWS)) begin
      res = ROW_W'(MAX_ROWS - 1);
    end else begin
      res = ROW_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

  function automatic logic [COL_W-1:0] last_col_of(input logic [DIM_W-1:0] v);
    logic [COL_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > DIM_W'(MAX_COLS)) begin
      res = COL_W'(MAX_COLS - 1);
    end else begin
      res = COL_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

  assign last_row = last_row_of(rows_in_use);
  assign last_col = last_col_of(cols_in_use);
  assign col_end  = (cur_col >= last_col);
  assign row_end  = (cur_row >= last_row);
  assign w_ext    = SUM_W'(cell_weight);
  assign up_sum   = row_sums[cur_col];

  always_comb begin
    if (cur_row == '0 && cur_col == '0) begin
      s        = w_ext;
      bit_left = 1'b0;
    end else if (cur_row == '0) begin
      s        = left_sum + w_ext;
      bit_left = 1'b1;
    end else if (cur_col == '0) begin
      s        = up_sum + w_ext;
      bit_left = 1'b0;
    end else if (left_sum > up_sum) begin
      s        = left_sum + w_ext;
      bit_left = 1'b1;
    end else begin
      s        = up_sum + w_ext;
      bit_left = 1'b0;
    end
  end

  assign status.map_end  = col_end && row_end;
  assign status.at_start = (pr == '0) && (pc == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        REG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      left_sum <= '0;
    end else if (cmd.cell_en) begin
      left_sum <= s;
      if (!col_end) begin
        cur_col <= cur_col + COL_W'(1);
      end else if (!row_end) begin
        cur_col <= '0;
        cur_row <= cur_row + ROW_W'(1);
      end else begin
        cur_col <= '0;
        cur_row <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_en) begin
      row_sums[cur_col]            <= s;
      from_left[{cur_row, cur_col}] <= bit_left;
    end
    if (cmd.rd_en) begin
      rd_bit <= from_left[{pr, pc}];
    end
  end

  // walk position; edges force the direction
  always_ff @(posedge clk) begin
    if (cmd.cell_en && status.map_end) begin
      pr  <= cur_row;
      pc  <= cur_col;
      tot <= s;
    end else if (cmd.step_en && !status.at_start) begin
      if (pr == '0) begin
        pc <= pc - COL_W'(1);
      end else if (pc == '0) begin
        pr <= pr - ROW_W'(1);
      end else if (rd_bit) begin
        pc <= pc - COL_W'(1);
      end else begin
        pr <= pr - ROW_W'(1);
      end
    end
  end

  assign path_row   = pr;
  assign path_col   = pc;
  assign best_total = tot;

endmodule

// File: rtl/core/grid_max_path_sum_with_backtrack.sv
// Top level: grid max path sum, right/down moves, with path backtrack.
// Depends on gmps_pkg, gmps_ctrl, gmps_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  cell in  | start & !busy        | cell_weight
//  result   | result_strobe        | path_row, path_col, best_total, last_of_path
//  config   | cfg_valid & cfg_ready| cfg_index, cfg_data
//
// Cells can arrive every cycle while busy is low.
// The final cell of a map starts the backtrack: each path cell gets a bit
// memory read, then an emit, so rows+cols-1 results come out.
// Synchronous reset clears position, left sum, sizes (4 rows, 5 cols), FSM.
// Results are strobed for one cycle; the receiver cannot stall. cfg_ready is 1.
module grid_max_path_sum_with_backtrack
  import gmps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WGT_W-1:0] cell_weight,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  output logic                    result_strobe,
  output logic [ROW_W-1:0]        path_row,
  output logic [COL_W-1:0]        path_col,
  output logic signed [SUM_W-1:0] best_total,
  output logic                    last_of_path
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready    = 1'b1;
  assign last_of_path = status.at_start;

  gmps_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy),
    .result_strobe (result_strobe)
  );

  gmps_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_weight (cell_weight),
    .status      (status),
    .path_row    (path_row),
    .path_col    (path_col),
    .best_total  (best_total)
  );

endmodule

// File: rtl/core/gmps_checker.sv
// Port-level checker for the grid max path sum block, bound to the top level.
// Depends on gmps_pkg and grid_max_path_sum_with_backtrack_defines.svh.
`include "grid_max_path_sum_with_backtrack_defines.svh"

module gmps_checker
  import gmps_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    busy,
  input logic                    result_strobe,
  input logic [ROW_W-1:0]        path_row,
  input logic [COL_W-1:0]        path_col,
  input logic signed [SUM_W-1:0] best_total,
  input logic                    last_of_path
);

  `GMPS_ASSERT_NOW(a_strobe_busy, result_strobe, busy, "result while not busy")
  `GMPS_ASSERT_NOW(a_last_at_origin, result_strobe && last_of_path,
    path_row == '0 && path_col == '0, "last transfer not at start cell")
  `GMPS_ASSERT_NEXT(a_strobe_gap, result_strobe, !result_strobe, "back-to-back results")
  `GMPS_ASSERT_NEXT(a_walk_busy, result_strobe && !last_of_path, busy, "walk ended early")
  `GMPS_ASSERT_NEXT(a_total_held, result_strobe && !last_of_path, $stable(best_total),
    "total changed within a path")

endmodule

bind grid_max_path_sum_with_backtrack gmps_checker u_gmps_checker (.*);
